### sv/ed_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ed_pkg
// Shared constants, types and arithmetic helpers of the edit distance engine.
// ----------------------------------------------------------------------------
package ed_pkg;

  localparam int MAX_QUERY_LEN = 32;
  localparam int DIST_BITS     = 8;
  localparam int QLEN_W        = $clog2(MAX_QUERY_LEN + 1);
  localparam int IDX_W         = (MAX_QUERY_LEN > 1) ? $clog2(MAX_QUERY_LEN) : 1;
  localparam int OUT_W         = 8;

  localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};
  localparam logic [OUT_W-1:0]     OUT_MAX  = {OUT_W{1'b1}};

  typedef enum logic {CMD_QUERY = 1'b0, CMD_CANDIDATE = 1'b1} cmd_t;

  typedef logic [DIST_BITS-1:0] dist_t;
  typedef logic [QLEN_W-1:0]    qlen_t;

  typedef struct packed {
    logic       valid;
    logic       init;
    logic [7:0] ch;
    dist_t      left;
    dist_t      diag;
  } tok_t;

  function automatic dist_t sat_inc(input dist_t v);
    sat_inc = (v == DIST_MAX) ? v : v + dist_t'(1);
  endfunction

  function automatic dist_t dmin(input dist_t a, input dist_t b);
    dmin = (a < b) ? a : b;
  endfunction

  function automatic dist_t init_val(input qlen_t idx);
    logic [QLEN_W+DIST_BITS-1:0] wide_idx;
    logic [QLEN_W+DIST_BITS-1:0] wide_max;
    wide_idx = (QLEN_W + DIST_BITS)'(idx);
    wide_max = (QLEN_W + DIST_BITS)'(DIST_MAX);
    init_val = (wide_idx < wide_max) ? DIST_BITS'(wide_idx) : DIST_MAX;
  endfunction

  function automatic logic [OUT_W-1:0] to_out(input dist_t v);
    logic [DIST_BITS+OUT_W-1:0] wide_v;
    logic [DIST_BITS+OUT_W-1:0] wide_max;
    wide_v   = (DIST_BITS + OUT_W)'(v);
    wide_max = (DIST_BITS + OUT_W)'(OUT_MAX);
    to_out   = (wide_v < wide_max) ? OUT_W'(wide_v) : OUT_MAX;
  endfunction

endpackage

`default_nettype wire

### sv/ed_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ed_in_if / ed_out_if
// Valid/ready channels for word bytes and for finished distances.
// ----------------------------------------------------------------------------
interface ed_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output cmd, output ch, output last, input ready);
  modport sink   (input valid, input cmd, input ch, input last, output ready);
endinterface

interface ed_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] distance;
  logic       query_truncated;

  modport source (output valid, output distance, output query_truncated, input ready);
  modport sink   (input valid, input distance, input query_truncated, output ready);
endinterface

`default_nettype wire

### sv/ed_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ed_cell
// One query position: holds its query byte and distance entry, updates the
// entry when the wavefront token passes and hands the token on.
// ----------------------------------------------------------------------------
module ed_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire ed_pkg::qlen_t idx,
  input  wire logic          wr_en,
  input  wire logic [7:0]    wr_ch,
  input  wire ed_pkg::tok_t  tok_in,
  output ed_pkg::tok_t       tok_out,
  output ed_pkg::dist_t      row
);
  import ed_pkg::*;

  logic [7:0] q_r;
  dist_t      row_r;
  dist_t      row_nxt;
  dist_t      up;
  tok_t       tok_r;
  tok_t       tok_nxt;

  always_comb begin
    up      = tok_in.init ? init_val(idx) : row_r;
    row_nxt = (q_r == tok_in.ch) ? tok_in.diag : sat_inc(tok_in.diag);
    row_nxt = dmin(row_nxt, sat_inc(up));
    row_nxt = dmin(row_nxt, sat_inc(tok_in.left));
    tok_nxt       = tok_in;
    tok_nxt.left  = row_nxt;
    tok_nxt.diag  = up;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r <= wr_ch;
    end
    if (!rst_n) begin
      row_r       <= '0;
      tok_r.valid <= 1'b0;
    end else begin
      if (tok_in.valid) begin
        row_r <= row_nxt;
      end
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;
  assign row     = row_r;

endmodule

`default_nettype wire

### sv/edit_distance_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// edit_distance_engine
// Levenshtein distance; query bytes transfer back to back while no candidate
// byte is in flight. A candidate byte holds off the input until its token has
// passed the stored query, so a new byte is not taken before then; a last
// byte's distance is then registered for output, later while it is stalled.
// Synchronous active-low reset empties the query, closes both words and
// clears the output valid flag.
// ----------------------------------------------------------------------------
module edit_distance_engine (
  input  wire logic clk,
  input  wire logic rst_n,
  ed_in_if.sink     in_s,
  ed_out_if.source  out_s
);
  import ed_pkg::*;

  qlen_t      qlen_r, qlen_nxt;
  logic       qopen_r, qopen_nxt;
  logic       copen_r, copen_nxt;
  logic       trunc_r, trunc_nxt;
  logic       busy_r, busy_nxt;
  qlen_t      pos_r, pos_nxt;
  logic       lastp_r, lastp_nxt;
  dist_t      row0_r, row0_nxt;
  tok_t       tok_r, tok_nxt;
  logic       ov_r, ov_nxt;
  logic [7:0] od_r, od_nxt;
  logic       ot_r, ot_nxt;

  logic       acc;
  logic       q_wr;
  qlen_t      q_base;
  dist_t      old0;
  dist_t      fin;
  logic       out_free;

  tok_t       tok_w [0:MAX_QUERY_LEN];
  dist_t      row_w [0:MAX_QUERY_LEN-1];

  assign tok_w[0] = tok_r;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_QUERY_LEN; gi++) begin : g_cell
      ed_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .idx     (QLEN_W'(gi + 1)),
        .wr_en   (q_wr && (q_base == QLEN_W'(gi))),
        .wr_ch   (in_s.ch),
        .tok_in  (tok_w[gi]),
        .tok_out (tok_w[gi+1]),
        .row     (row_w[gi])
      );
    end
  endgenerate

  assign acc      = in_s.valid && in_s.ready;
  assign q_base   = qopen_r ? qlen_r : '0;
  assign q_wr     = acc && (in_s.cmd == CMD_QUERY) &&
                    (q_base < QLEN_W'(MAX_QUERY_LEN));
  assign old0     = copen_r ? row0_r : '0;
  assign out_free = !ov_r || out_s.ready;
  assign fin      = (qlen_r == '0) ? row0_r : row_w[IDX_W'(qlen_r - qlen_t'(1))];

  always_comb begin
    qlen_nxt  = qlen_r;
    qopen_nxt = qopen_r;
    copen_nxt = copen_r;
    trunc_nxt = trunc_r;
    busy_nxt  = busy_r;
    pos_nxt   = pos_r;
    lastp_nxt = lastp_r;
    row0_nxt  = row0_r;
    tok_nxt   = tok_r;
    ov_nxt    = ov_r && !out_s.ready;
    od_nxt    = od_r;
    ot_nxt    = ot_r;
    tok_nxt.valid = 1'b0;

    if (acc && (in_s.cmd == CMD_QUERY)) begin
      copen_nxt = 1'b0;
      qopen_nxt = !in_s.last;
      trunc_nxt = qopen_r ? trunc_r : 1'b0;
      if (q_wr) begin
        qlen_nxt = q_base + qlen_t'(1);
      end else begin
        qlen_nxt  = q_base;
        trunc_nxt = 1'b1;
      end
    end else if (acc) begin
      qopen_nxt     = 1'b0;
      copen_nxt     = !in_s.last;
      busy_nxt      = 1'b1;
      pos_nxt       = '0;
      lastp_nxt     = in_s.last;
      row0_nxt      = sat_inc(old0);
      tok_nxt.valid = 1'b1;
      tok_nxt.init  = !copen_r;
      tok_nxt.ch    = in_s.ch;
      tok_nxt.left  = sat_inc(old0);
      tok_nxt.diag  = old0;
    end

    if (busy_r) begin
      if (pos_r != qlen_r) begin
        pos_nxt = pos_r + qlen_t'(1);
      end else if (!lastp_r) begin
        busy_nxt = 1'b0;
      end else if (out_free) begin
        busy_nxt = 1'b0;
        ov_nxt   = 1'b1;
        od_nxt   = to_out(fin);
        ot_nxt   = trunc_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    od_r <= od_nxt;
    ot_r <= ot_nxt;
    if (!rst_n) begin
      qlen_r      <= '0;
      qopen_r     <= 1'b0;
      copen_r     <= 1'b0;
      trunc_r     <= 1'b0;
      busy_r      <= 1'b0;
      pos_r       <= '0;
      lastp_r     <= 1'b0;
      row0_r      <= '0;
      tok_r.valid <= 1'b0;
      ov_r        <= 1'b0;
    end else begin
      qlen_r  <= qlen_nxt;
      qopen_r <= qopen_nxt;
      copen_r <= copen_nxt;
      trunc_r <= trunc_nxt;
      busy_r  <= busy_nxt;
      pos_r   <= pos_nxt;
      lastp_r <= lastp_nxt;
      row0_r  <= row0_nxt;
      tok_r   <= tok_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign in_s.ready            = !busy_r;
  assign out_s.valid           = ov_r;
  assign out_s.distance        = od_r;
  assign out_s.query_truncated = ot_r;

endmodule

`default_nettype wire
